/* hw/rtl/vas_pkg.sv */
`timescale 1ns / 1ps

package vas_pkg;

    localparam int MAX_SENDERS   = 64;
    localparam int MAX_RECEIVERS = 64;
    localparam int VALUE_WIDTH   = 16;

    localparam int SND_W     = 6;
    localparam int RCV_W     = 6;
    localparam int CNT_W     = 7;
    localparam int CFG_IDX_W = 1;

    localparam int SND_AW    = $clog2(MAX_SENDERS);
    localparam int RCV_AW    = $clog2(MAX_RECEIVERS);
    localparam int TIE_DEPTH = MAX_SENDERS * MAX_RECEIVERS;
    localparam int TIE_AW    = $clog2(TIE_DEPTH);
    localparam int DEG_W     = 7;
    localparam int TOTAL_W   = 13;

    localparam int SND_RESET = (64 > MAX_SENDERS) ? MAX_SENDERS : 64;
    localparam int RCV_RESET = (64 > MAX_RECEIVERS) ? MAX_RECEIVERS : 64;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 48;

    typedef enum logic [1:0] {
        CMD_SET,
        CMD_INCREASE,
        CMD_READ,
        CMD_CLEAR
    } t_cmd;

    typedef enum logic [1:0] {
        STAT_OK,
        STAT_BAD_SENDER,
        STAT_BAD_RECEIVER
    } t_status;

    typedef enum logic [1:0] {
        EV_NONE,
        EV_INTRODUCED,
        EV_WITHDRAWN,
        EV_CLEARED
    } t_event;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SENDER_COUNT,
        REG_RECEIVER_COUNT
    } t_reg_idx;

    // request as it arrives on the stream, command in the low bits
    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] amount;
        logic [RCV_W-1:0]              receiver;
        logic [SND_W-1:0]              sender;
        t_cmd                          cmd;
    } t_req;

    typedef struct packed {
        t_status status;
        t_req    req;
    } t_item;

    typedef struct packed {
        logic [TOTAL_W-1:0] pairs;
        logic               clear;
    } t_cfg;

    // result as it leaves on the stream, status in the low bits
    typedef struct packed {
        logic                          complete;
        logic [TOTAL_W-1:0]            total;
        logic [DEG_W-1:0]              in_degree;
        logic [DEG_W-1:0]              out_degree;
        t_event                        event_res;
        logic signed [VALUE_WIDTH-1:0] tie_value;
        t_status                       status;
    } t_result;

endpackage

/* hw/rtl/vas_ram.sv */
`timescale 1ns / 1ps

module vas_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/vas_front.sv */
`timescale 1ns / 1ps

module vas_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  vas_pkg::t_req                 i_req,
    output logic                          o_ready,
    input  logic                          i_cfg_we,
    input  logic [vas_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [vas_pkg::CNT_W-1:0]     i_cfg_data,
    input  logic                          i_busy,
    input  logic                          i_q_full,
    output logic                          o_q_push,
    output vas_pkg::t_item                o_q_item,
    output vas_pkg::t_cfg                 o_cfg
);

    import vas_pkg::*;

    logic [CNT_W-1:0]   r_senders;
    logic [CNT_W-1:0]   r_receivers;
    logic [TOTAL_W-1:0] r_pairs;
    logic [CNT_W-1:0]   n_senders;
    logic [CNT_W-1:0]   n_receivers;
    t_status            status;

    always_comb begin
        n_senders   = r_senders;
        n_receivers = r_receivers;
        if (i_cfg_we && i_cfg_idx == REG_SENDER_COUNT) begin
            n_senders = (i_cfg_data > CNT_W'(MAX_SENDERS)) ? CNT_W'(MAX_SENDERS) : i_cfg_data;
        end
        if (i_cfg_we && i_cfg_idx == REG_RECEIVER_COUNT) begin
            n_receivers = (i_cfg_data > CNT_W'(MAX_RECEIVERS)) ?
                          CNT_W'(MAX_RECEIVERS) : i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_senders   <= CNT_W'(SND_RESET);
            r_receivers <= CNT_W'(RCV_RESET);
            r_pairs     <= TOTAL_W'(SND_RESET * RCV_RESET);
        end else begin
            r_senders   <= n_senders;
            r_receivers <= n_receivers;
            r_pairs     <= TOTAL_W'(n_senders) * TOTAL_W'(n_receivers);
        end
    end

    // sender is checked before receiver; clear ignores both
    always_comb begin
        if (i_req.cmd == CMD_CLEAR) begin
            status = STAT_OK;
        end else if (CNT_W'(i_req.sender) >= r_senders) begin
            status = STAT_BAD_SENDER;
        end else if (CNT_W'(i_req.receiver) >= r_receivers) begin
            status = STAT_BAD_RECEIVER;
        end else begin
            status = STAT_OK;
        end
    end

    assign o_ready         = !i_q_full && !i_busy;
    assign o_q_push        = i_valid && o_ready;
    assign o_q_item.status = status;
    assign o_q_item.req    = i_req;
    assign o_cfg.pairs     = r_pairs;
    assign o_cfg.clear     = i_cfg_we;

endmodule

/* hw/rtl/vas_queue.sv */
`timescale 1ns / 1ps

module vas_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  vas_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output vas_pkg::t_item o_item
);

    import vas_pkg::*;

    t_item               r_slot [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_CW-1:0] r_count;

    function automatic logic [QUEUE_AW-1:0] advance(input logic [QUEUE_AW-1:0] ptr);
        return (ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : ptr + QUEUE_AW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= advance(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= advance(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QUEUE_CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - QUEUE_CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

    assign o_full  = (r_count == QUEUE_CW'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_slot[r_rd_ptr];

endmodule

/* hw/rtl/vas_back.sv */
`timescale 1ns / 1ps

module vas_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  vas_pkg::t_cfg    i_cfg,
    input  logic             i_q_valid,
    input  vas_pkg::t_item   i_q_item,
    output logic             o_q_pop,
    output logic             o_busy,
    output logic             o_valid,
    input  logic             i_ready,
    output vas_pkg::t_result o_result
);

    import vas_pkg::*;

    typedef enum logic [1:0] {
        S_SWEEP,
        S_IDLE,
        S_EXEC
    } t_state;

    t_state             r_state;
    logic [TIE_AW-1:0]  r_sweep;
    logic [TOTAL_W-1:0] r_total;
    t_item              r_item;
    logic [TIE_AW-1:0]  r_addr;
    logic               r_out_valid;
    t_result            r_out;

    logic                          out_free;
    logic                          head_rmw;
    logic [TIE_AW-1:0]             head_addr;
    logic                          rd_en;
    logic                          sweeping;
    logic                          exec_go;
    logic signed [VALUE_WIDTH-1:0] old_val;
    logic signed [VALUE_WIDTH:0]   sum;
    logic signed [VALUE_WIDTH-1:0] sat_sum;
    logic signed [VALUE_WIDTH-1:0] new_val;
    logic                          writes;
    logic                          intro;
    logic                          withdraw;
    logic [DEG_W-1:0]              odeg_q;
    logic [DEG_W-1:0]              ideg_q;
    logic [DEG_W-1:0]              odeg_new;
    logic [DEG_W-1:0]              ideg_new;
    logic [TOTAL_W-1:0]            total_new;
    t_result                       early_res;
    t_result                       exec_res;

    logic                    tie_we;
    logic [TIE_AW-1:0]       tie_waddr;
    logic [VALUE_WIDTH-1:0]  tie_wdata;
    logic [VALUE_WIDTH-1:0]  tie_rdata;
    logic                    out_we;
    logic [SND_AW-1:0]       out_waddr;
    logic [DEG_W-1:0]        out_wdata;
    logic                    in_we;
    logic [RCV_AW-1:0]       in_waddr;
    logic [DEG_W-1:0]        in_wdata;

    assign out_free  = !r_out_valid || i_ready;
    assign sweeping  = (r_state == S_SWEEP);
    assign head_rmw  = (i_q_item.req.cmd != CMD_CLEAR) && (i_q_item.status == STAT_OK);
    assign head_addr = TIE_AW'(i_q_item.req.sender) * TIE_AW'(MAX_RECEIVERS)
                     + TIE_AW'(i_q_item.req.receiver);
    // a request with an early result needs the output register on pop
    assign o_q_pop   = (r_state == S_IDLE) && i_q_valid && !i_cfg.clear
                     && (head_rmw || out_free);
    assign rd_en     = o_q_pop && head_rmw;
    assign exec_go   = (r_state == S_EXEC) && out_free;

    // read-modify-write of one tie
    always_comb begin
        old_val = tie_rdata;
        sum     = {old_val[VALUE_WIDTH-1], old_val}
                + {r_item.req.amount[VALUE_WIDTH-1], r_item.req.amount};
        if (sum[VALUE_WIDTH] != sum[VALUE_WIDTH-1]) begin
            sat_sum = sum[VALUE_WIDTH] ? {1'b1, {(VALUE_WIDTH-1){1'b0}}}
                                       : {1'b0, {(VALUE_WIDTH-1){1'b1}}};
        end else begin
            sat_sum = sum[VALUE_WIDTH-1:0];
        end
        case (r_item.req.cmd)
            CMD_SET:      new_val = r_item.req.amount;
            CMD_INCREASE: new_val = sat_sum;
            default:      new_val = old_val;
        endcase
        writes   = (r_item.req.cmd == CMD_SET) || (r_item.req.cmd == CMD_INCREASE);
        intro    = writes && (old_val == '0) && (new_val != '0);
        withdraw = writes && (old_val != '0) && (new_val == '0);
        odeg_new  = odeg_q;
        ideg_new  = ideg_q;
        total_new = r_total;
        if (intro) begin
            odeg_new  = odeg_q + DEG_W'(1);
            ideg_new  = ideg_q + DEG_W'(1);
            total_new = r_total + TOTAL_W'(1);
        end else if (withdraw) begin
            odeg_new  = odeg_q - DEG_W'(1);
            ideg_new  = ideg_q - DEG_W'(1);
            total_new = r_total - TOTAL_W'(1);
        end
        exec_res.status     = STAT_OK;
        exec_res.tie_value  = new_val;
        exec_res.event_res  = intro ? EV_INTRODUCED : (withdraw ? EV_WITHDRAWN : EV_NONE);
        exec_res.out_degree = odeg_new;
        exec_res.in_degree  = ideg_new;
        exec_res.total      = total_new;
        exec_res.complete   = (total_new == i_cfg.pairs);
    end

    // clear and out-of-range requests answer without touching the tables
    always_comb begin
        early_res.status     = i_q_item.status;
        early_res.tie_value  = '0;
        early_res.out_degree = '0;
        early_res.in_degree  = '0;
        if (i_q_item.req.cmd == CMD_CLEAR) begin
            early_res.event_res = EV_CLEARED;
            early_res.total     = '0;
            early_res.complete  = (i_cfg.pairs == '0);
        end else begin
            early_res.event_res = EV_NONE;
            early_res.total     = r_total;
            early_res.complete  = (r_total == i_cfg.pairs);
        end
    end

    assign tie_we    = sweeping || (exec_go && writes);
    assign tie_waddr = sweeping ? r_sweep : r_addr;
    assign tie_wdata = sweeping ? '0 : new_val;
    assign out_we    = (sweeping && (r_sweep < TIE_AW'(MAX_SENDERS)))
                     || (exec_go && (intro || withdraw));
    assign out_waddr = sweeping ? SND_AW'(r_sweep) : SND_AW'(r_item.req.sender);
    assign out_wdata = sweeping ? '0 : odeg_new;
    assign in_we     = (sweeping && (r_sweep < TIE_AW'(MAX_RECEIVERS)))
                     || (exec_go && (intro || withdraw));
    assign in_waddr  = sweeping ? RCV_AW'(r_sweep) : RCV_AW'(r_item.req.receiver);
    assign in_wdata  = sweeping ? '0 : ideg_new;

    vas_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(TIE_DEPTH)) u_tie_ram (
        .i_clk   (i_clk),
        .i_we    (tie_we),
        .i_waddr (tie_waddr),
        .i_wdata (tie_wdata),
        .i_re    (rd_en),
        .i_raddr (head_addr),
        .o_rdata (tie_rdata)
    );

    vas_ram #(.WIDTH(DEG_W), .DEPTH(MAX_SENDERS)) u_out_ram (
        .i_clk   (i_clk),
        .i_we    (out_we),
        .i_waddr (out_waddr),
        .i_wdata (out_wdata),
        .i_re    (rd_en),
        .i_raddr (SND_AW'(i_q_item.req.sender)),
        .o_rdata (odeg_q)
    );

    vas_ram #(.WIDTH(DEG_W), .DEPTH(MAX_RECEIVERS)) u_in_ram (
        .i_clk   (i_clk),
        .i_we    (in_we),
        .i_waddr (in_waddr),
        .i_wdata (in_wdata),
        .i_re    (rd_en),
        .i_raddr (RCV_AW'(i_q_item.req.receiver)),
        .o_rdata (ideg_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SWEEP;
            r_sweep     <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg.clear) begin
                r_state <= S_SWEEP;
                r_sweep <= '0;
                r_total <= '0;
            end else begin
                case (r_state)
                    S_SWEEP: begin
                        if (r_sweep == TIE_AW'(TIE_DEPTH - 1)) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_sweep <= r_sweep + TIE_AW'(1);
                        end
                    end
                    S_IDLE: begin
                        if (o_q_pop) begin
                            if (head_rmw) begin
                                r_item  <= i_q_item;
                                r_addr  <= head_addr;
                                r_state <= S_EXEC;
                            end else begin
                                r_out       <= early_res;
                                r_out_valid <= 1'b1;
                                if (i_q_item.req.cmd == CMD_CLEAR) begin
                                    r_total <= '0;
                                    r_sweep <= '0;
                                    r_state <= S_SWEEP;
                                end
                            end
                        end
                    end
                    S_EXEC: begin
                        // hold the write until the result has somewhere to go
                        if (out_free) begin
                            r_out       <= exec_res;
                            r_out_valid <= 1'b1;
                            r_total     <= total_new;
                            r_state     <= S_IDLE;
                        end
                    end
                    default: begin
                        r_state <= S_IDLE;
                    end
                endcase
            end
        end
    end

    assign o_busy   = sweeping;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

/* hw/rtl/valued_adjacency_store.sv */
`timescale 1ns / 1ps
// channel   direction  signals                    payload
// s_axis    in         tvalid tready tdata[31:0]  request
// m_axis    out        tvalid tready tdata[47:0]  result
// cfg       in         i_cfg_we i_cfg_idx i_cfg_data  sender/receiver count
//
// Set, increase and read pop in S_IDLE, which reads the tie and both degree memories
// (the read is registered), and finish in S_EXEC, which writes set and increase back.
// Out-of-range and clear requests answer from S_IDLE, registered on pop. A clear, a
// count write and reset each start a clearing pass over the tie memory, during
// which s_axis_tready is low. A 2-entry queue separates intake from execution;
// a full output register holds the update in S_EXEC and the pop of an early answer.

module valued_adjacency_store (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [1:0] command, [7:2] sender, [13:8] receiver, [29:14] amount
    input  logic [vas_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [1:0] status, [17:2] tie_value, [19:18] event_res, [26:20] sender_out_degree,
    // [33:27] receiver_in_degree, [46:34] total_ties, [47] network_complete
    output logic [vas_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                          i_cfg_we,
    input  logic [vas_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [vas_pkg::CNT_W-1:0]     i_cfg_data
);

    import vas_pkg::*;

    t_req    req;
    t_item   push_item;
    t_item   head_item;
    t_cfg    cfg;
    t_result result;
    logic    q_push;
    logic    q_full;
    logic    q_pop;
    logic    q_valid;
    logic    busy;

    assign req = t_req'(s_axis_tdata[$bits(t_req)-1:0]);

    vas_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .i_req      (req),
        .o_ready    (s_axis_tready),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_busy     (busy),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_item   (push_item),
        .o_cfg      (cfg)
    );

    vas_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (push_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (head_item)
    );

    vas_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_q_valid (q_valid),
        .i_q_item  (head_item),
        .o_q_pop   (q_pop),
        .o_busy    (busy),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_result  (result)
    );

    assign m_axis_tdata = result;

    a_cfg_blocks_intake: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> !s_axis_tready)
        else $error("request accepted right after a count write");

    a_reset_blocks_intake: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !s_axis_tready)
        else $error("request accepted before the clearing pass");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && result.event_res == EV_CLEARED) |-> (result.total == '0))
        else $error("clear result reports ties");

    a_error_is_inert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && result.status != STAT_OK) |->
        (result.event_res == EV_NONE && result.out_degree == '0
         && result.in_degree == '0 && result.tie_value == '0))
        else $error("out-of-range request changed or reported a tie");

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps

module tb;
    import vas_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int PHASES         = 8;

    class network_tracker;
        logic signed [VALUE_WIDTH-1:0] ties [MAX_SENDERS][MAX_RECEIVERS];
        int unsigned out_deg [MAX_SENDERS];
        int unsigned in_deg [MAX_RECEIVERS];
        int unsigned tie_count;
        int unsigned sender_reg;
        int unsigned receiver_reg;
        t_result     expected_results [$];
        int          mismatches;
        int          results_seen;
        int          introduced;
        int          withdrawn;
        int          cleared;
        int          rejected;
        int          completed;

        function new();
            sender_reg   = SND_RESET;
            receiver_reg = RCV_RESET;
            wipe();
        endfunction

        function void wipe();
            foreach (ties[s, r]) ties[s][r] = '0;
            foreach (out_deg[s]) out_deg[s] = 0;
            foreach (in_deg[r]) in_deg[r] = 0;
            tie_count = 0;
        endfunction

        // a size change always leaves an empty network
        function void write_count(t_reg_idx idx, int unsigned value);
            if (idx == REG_SENDER_COUNT) sender_reg = value & 'h7F;
            else receiver_reg = value & 'h7F;
            wipe();
        endfunction

        function int unsigned senders_live();
            return (sender_reg > MAX_SENDERS) ? MAX_SENDERS : sender_reg;
        endfunction

        function int unsigned receivers_live();
            return (receiver_reg > MAX_RECEIVERS) ? MAX_RECEIVERS : receiver_reg;
        endfunction

        function logic signed [VALUE_WIDTH-1:0] peek(int s, int r);
            return ties[s][r];
        endfunction

        function void note_request(t_req req);
            int unsigned ns;
            int unsigned nr;
            int          old_v;
            int          new_v;
            t_result     e;
            ns = senders_live();
            nr = receivers_live();
            e = '0;
            e.status    = STAT_OK;
            e.event_res = EV_NONE;
            if (req.cmd == CMD_CLEAR) begin
                wipe();
                e.event_res = EV_CLEARED;
                cleared++;
            end else if (req.sender >= ns) begin
                e.status = STAT_BAD_SENDER;
                rejected++;
            end else if (req.receiver >= nr) begin
                e.status = STAT_BAD_RECEIVER;
                rejected++;
            end else begin
                old_v = ties[req.sender][req.receiver];
                new_v = old_v;
                if (req.cmd != CMD_READ) begin
                    if (req.cmd == CMD_INCREASE) new_v = old_v + int'(req.amount);
                    else new_v = int'(req.amount);
                    if (new_v > 32767) new_v = 32767;
                    if (new_v < -32768) new_v = -32768;
                    ties[req.sender][req.receiver] = new_v[VALUE_WIDTH-1:0];
                    if (old_v != 0 && new_v == 0) begin
                        out_deg[req.sender]--;
                        in_deg[req.receiver]--;
                        tie_count--;
                        e.event_res = EV_WITHDRAWN;
                        withdrawn++;
                    end else if (old_v == 0 && new_v != 0) begin
                        out_deg[req.sender]++;
                        in_deg[req.receiver]++;
                        tie_count++;
                        e.event_res = EV_INTRODUCED;
                        introduced++;
                    end
                end
                e.tie_value  = new_v[VALUE_WIDTH-1:0];
                e.out_degree = DEG_W'(out_deg[req.sender]);
                e.in_degree  = DEG_W'(in_deg[req.receiver]);
            end
            e.total    = TOTAL_W'(tie_count);
            e.complete = (tie_count == ns * nr);
            if (e.complete) completed++;
            expected_results.insert(expected_results.size(), e);
        endfunction

        function void flag(string field, int want, int got);
            mismatches++;
            if (mismatches <= 10)
                $display("MISMATCH result %0d %s: expected %0d, got %0d",
                         results_seen, field, want, got);
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] raw);
            t_result got;
            t_result want;
            got = t_result'(raw);
            results_seen++;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("MISMATCH result %0d arrived with no request pending: 0x%h",
                             results_seen, raw);
                return;
            end
            want = expected_results.pop_front();
            if (got.status !== want.status) flag("status", want.status, got.status);
            if (got.tie_value !== want.tie_value)
                flag("tie_value", want.tie_value, got.tie_value);
            if (got.event_res !== want.event_res)
                flag("event_res", want.event_res, got.event_res);
            if (got.out_degree !== want.out_degree)
                flag("sender_out_degree", want.out_degree, got.out_degree);
            if (got.in_degree !== want.in_degree)
                flag("receiver_in_degree", want.in_degree, got.in_degree);
            if (got.total !== want.total) flag("total_ties", want.total, got.total);
            if (got.complete !== want.complete)
                flag("network_complete", want.complete, got.complete);
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       s_axis_tvalid;
    logic                       s_axis_tready;
    logic [IN_TDATA_W-1:0]      s_axis_tdata;
    logic                       m_axis_tvalid;
    logic                       m_axis_tready;
    logic [OUT_TDATA_W-1:0]     m_axis_tdata;
    logic                       i_cfg_we;
    logic [CFG_IDX_W-1:0]       i_cfg_idx;
    logic [CNT_W-1:0]           i_cfg_data;

    network_tracker tracker;
    bit             source_gaps;
    bit             sink_stalls;
    int             sink_hold;
    int             idle_cycles;
    int             size_changes;

    int unsigned phase_senders   [PHASES] = '{64, 3, 1, 127, 0, 6, 8, 2};
    int unsigned phase_receivers [PHASES] = '{64, 4, 1, 64, 9, 0, 8, 64};
    int          phase_items     [PHASES] = '{350, 300, 150, 200, 100, 100, 300, 250};

    valued_adjacency_store DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // mostly a small hot corner so ties get revisited, sometimes the edge or anything
    function automatic logic [SND_W-1:0] pick_index(int unsigned n);
        int roll;
        roll = $urandom_range(0, 99);
        if (n == 0 || roll < 12) return SND_W'($urandom_range(0, 63));
        if (roll < 18) return (n < 64) ? SND_W'(n) : SND_W'(63);
        return SND_W'($urandom_range(0, ((n < 8) ? n : 8) - 1));
    endfunction

    function automatic t_req make_req(t_cmd c, int s, int r, int a);
        t_req q;
        q.cmd      = c;
        q.sender   = SND_W'(s);
        q.receiver = RCV_W'(r);
        q.amount   = VALUE_WIDTH'(a);
        return q;
    endfunction

    function automatic t_req random_request();
        t_req q;
        int   roll;
        roll = $urandom_range(0, 999);
        if (roll < 8) q.cmd = CMD_CLEAR;
        else if (roll < 360) q.cmd = CMD_SET;
        else if (roll < 720) q.cmd = CMD_INCREASE;
        else q.cmd = CMD_READ;
        q.sender   = pick_index(tracker.senders_live());
        q.receiver = pick_index(tracker.receivers_live());
        roll = $urandom_range(0, 99);
        if (roll < 30) begin
            q.amount = VALUE_WIDTH'(int'($urandom_range(0, 8)) - 4);
        end else if (roll < 45) begin
            case ($urandom_range(0, 3))
                0: q.amount = 16'h7FFF;
                1: q.amount = 16'h8000;
                2: q.amount = 16'h8001;
                default: q.amount = 16'h7FFE;
            endcase
        end else if (roll < 60 && q.cmd == CMD_INCREASE) begin
            // cancel the stored value to force a withdrawal
            q.amount = VALUE_WIDTH'(-int'(tracker.peek(q.sender, q.receiver)));
        end else begin
            q.amount = VALUE_WIDTH'($urandom);
        end
        return q;
    endfunction

    task automatic send_request(input t_req req);
        int gap;
        gap = source_gaps ? pick_gap() : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {{(IN_TDATA_W - $bits(t_req)){1'b0}}, req};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (tracker.pending() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // wait out any clearing pass so the write lands on an idle block
    task automatic write_count(input t_reg_idx idx, input int unsigned value);
        repeat (2) @(posedge i_clk);
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = CNT_W'(value);
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
    endtask

    task automatic resize(input int unsigned senders, input int unsigned receivers);
        write_count(REG_SENDER_COUNT, senders);
        write_count(REG_RECEIVER_COUNT, receivers);
        size_changes++;
    endtask

    always @(negedge i_clk) begin
        if (!sink_stalls) begin
            m_axis_tready = 1'b1;
        end else if (sink_hold > 0) begin
            m_axis_tready = 1'b0;
            sink_hold--;
        end else begin
            m_axis_tready = 1'b1;
            sink_hold = pick_gap();
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                tracker.note_request(t_req'(s_axis_tdata[$bits(t_req)-1:0]));
            if (m_axis_tvalid && m_axis_tready) tracker.check_result(m_axis_tdata);
            if (i_cfg_we) tracker.write_count(t_reg_idx'(i_cfg_idx), i_cfg_data);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog: no request or result moved for %0d cycles", idle_cycles);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin
        int p;
        int n;
        tracker       = new();
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b1;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = REG_SENDER_COUNT;
        i_cfg_data    = '0;
        source_gaps   = 1'b1;
        sink_stalls   = 1'b1;
        sink_hold     = 0;
        idle_cycles   = 0;
        size_changes  = 1;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // full-size network: saturation both ways, withdrawal by set and by increase
        send_request(make_req(CMD_SET, 0, 0, 32767));
        send_request(make_req(CMD_INCREASE, 0, 0, 1));
        send_request(make_req(CMD_SET, 63, 63, -32768));
        send_request(make_req(CMD_INCREASE, 63, 63, -32768));
        send_request(make_req(CMD_READ, 63, 63, 0));
        send_request(make_req(CMD_READ, 5, 9, -1));
        send_request(make_req(CMD_SET, 0, 0, 0));
        send_request(make_req(CMD_INCREASE, 1, 2, 5));
        send_request(make_req(CMD_INCREASE, 1, 2, -5));
        send_request(make_req(CMD_SET, 1, 2, 0));
        drain();

        // 2 x 2: range errors, fill to complete, then clear
        resize(2, 2);
        send_request(make_req(CMD_SET, 2, 0, 7));
        send_request(make_req(CMD_SET, 0, 2, 7));
        send_request(make_req(CMD_READ, 63, 63, 0));
        send_request(make_req(CMD_SET, 0, 0, 1));
        send_request(make_req(CMD_SET, 0, 1, -1));
        send_request(make_req(CMD_SET, 1, 0, 100));
        send_request(make_req(CMD_SET, 1, 1, 32767));
        send_request(make_req(CMD_READ, 1, 1, 0));
        send_request(make_req(CMD_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63),
                              int'($urandom_range(0, 65535))));
        drain();

        // no senders at all: the empty network counts as complete
        write_count(REG_SENDER_COUNT, 0);
        size_changes++;
        send_request(make_req(CMD_SET, 0, 0, 5));
        send_request(make_req(CMD_CLEAR, 63, 63, -1));
        drain();

        for (p = 0; p < PHASES; p++) begin
            resize(phase_senders[p], phase_receivers[p]);
            source_gaps = (p % 3 != 1);
            sink_stalls = (p % 4 != 2);
            for (n = 0; n < phase_items[p]; n++) send_request(random_request());
            drain();
        end

        $display("Checked %0d results over %0d network sizes: %0d ties introduced, %0d withdrawn,",
                 tracker.results_seen, size_changes, tracker.introduced, tracker.withdrawn);
        $display("%0d clears, %0d out-of-range requests, %0d results with the network complete.",
                 tracker.cleared, tracker.rejected, tracker.completed);
        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches, %0d results still pending",
                     tracker.mismatches, tracker.pending());
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/vas_pkg.sv
hw/rtl/vas_ram.sv
hw/rtl/vas_front.sv
hw/rtl/vas_queue.sv
hw/rtl/vas_back.sv
hw/rtl/valued_adjacency_store.sv
test/tb.sv
